// File: hw/rtl/look_at_view_matrix_top_assert.svh
// Assertion macros for the look-at view matrix block.
// Used by look_at_view_matrix_top; needs clk and rst in scope.
`ifndef LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LAV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LAV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/lav_pkg.sv
// Shared constants and types for the look-at view matrix pipeline.
// No dependencies.
package lav_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 32;
  localparam int COMP_W    = FRAC_BITS + 2;
  localparam int DIFF_W    = IN_W + 1;
  localparam int VEC_W     = (2 * FRAC_BITS + 3 > DIFF_W) ? 2 * FRAC_BITS + 3 : DIFF_W;
  localparam int WM_W      = 30;
  localparam int SQ_W      = 2 * WM_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int COL_W     = 2;
  localparam logic [COL_W-1:0] COL_LAST = 2'd3;

  typedef logic [2:0][COMP_W-1:0] cvec_t;
  typedef logic [2:0][VEC_W-1:0]  wvec_t;
  typedef logic [2:0][IN_W-1:0]   evec_t;
  typedef logic [3:0][3:0][IN_W-1:0] mat_t;

  typedef struct packed {
    evec_t eye;
    cvec_t f;
    cvec_t r;
    logic  degen;
  } side_t;

endpackage

// File: hw/rtl/lav_unit3.sv
// Pipelined vector normaliser: alignment, sum of squares, bit-serial square
// root and one quotient bit per stage division. Depends on lav_pkg.
module lav_unit3 import lav_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  wvec_t in_vec,
  input  side_t in_side,
  output logic  out_valid,
  output cvec_t out_vec,
  output logic  out_zero,
  output side_t out_side
);

  localparam int POS_W  = $clog2(VEC_W);
  localparam int SQRT_N = ROOT_W;
  localparam int DIV_N  = Q_W;
  localparam int REM_W  = ROOT_W + 4;
  localparam int DREM_W = ROOT_W + 1;
  localparam int EXT_W  = VEC_W + WM_W - 1;

  typedef struct packed {
    logic [REM_W-1:0]       rem;
    logic [ROOT_W-1:0]      root;
    logic [SUM_W-1:0]       n;
    logic [2:0][WM_W-1:0]   wmag;
    logic [2:0]             sgn;
    logic                   zero;
    side_t                  side;
  } sq_t;

  typedef struct packed {
    logic [2:0][DREM_W-1:0] rem;
    logic [2:0][Q_W-1:0]    q;
    logic [ROOT_W-1:0]      rt;
    logic [2:0]             wlsb;
    logic [2:0]             sgn;
    logic                   zero;
    side_t                  side;
  } dv_t;

  function automatic sq_t sq_step(sq_t s);
    sq_t              o;
    logic [REM_W-1:0] rs;
    logic [REM_W-1:0] tr;
    o  = s;
    rs = {s.rem[REM_W-3:0], s.n[SUM_W-1 -: 2]};
    tr = {{(REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
    if (rs >= tr) begin
      o.rem  = rs - tr;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rs;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    o.n = {s.n[SUM_W-3:0], 2'b00};
    return o;
  endfunction

  function automatic dv_t dv_step(dv_t s, logic first);
    dv_t               o;
    logic [DREM_W-1:0] r2;
    logic              ge;
    o = s;
    for (int k = 0; k < 3; k++) begin
      r2 = {s.rem[k][DREM_W-2:0], first ? s.wlsb[k] : 1'b0};
      ge = (r2 >= {1'b0, s.rt});
      o.rem[k] = ge ? r2 - {1'b0, s.rt} : r2;
      o.q[k]   = {s.q[k][Q_W-2:0], ge};
    end
    return o;
  endfunction

  // Stage 1: magnitudes and signs
  logic                   v1;
  logic [2:0][VEC_W-1:0]  mag1;
  logic [2:0]             sgn1;
  side_t                  side1;
  // Stage 2: aligned magnitudes
  logic                   v2;
  logic [2:0][WM_W-1:0]   wmag2;
  logic [2:0]             sgn2;
  logic                   zero2;
  side_t                  side2;
  // Stage 3: squares
  logic                   v3;
  logic [2:0][SQ_W-1:0]   sq3;
  logic [2:0][WM_W-1:0]   wmag3;
  logic [2:0]             sgn3;
  logic                   zero3;
  side_t                  side3;
  // Stage 4: sum of squares
  logic                   v4;
  logic [SUM_W-1:0]       sum4;
  logic [2:0][WM_W-1:0]   wmag4;
  logic [2:0]             sgn4;
  logic                   zero4;
  side_t                  side4;

  logic                   vsq [SQRT_N];
  sq_t                    sq  [SQRT_N];
  logic                   vdv [DIV_N];
  dv_t                    dv  [DIV_N];

  logic [VEC_W-1:0]       ormag;
  logic [POS_W-1:0]       pos;
  logic [2:0][VEC_W-1:0]  mag_in;
  logic [2:0][WM_W-1:0]   wmag_c;
  logic [EXT_W-1:0]       ext;
  sq_t                    sq_init;
  dv_t                    dv_init;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_in[k] = in_vec[k][VEC_W-1] ? (~in_vec[k] + 1'b1) : in_vec[k];
    end
  end

  // The leading one of the OR of the magnitudes is the leading one of the largest.
  always_comb begin
    ormag = mag1[0] | mag1[1] | mag1[2];
    pos   = '0;
    for (int i = 0; i < VEC_W; i++) begin
      if (ormag[i]) begin
        pos = POS_W'(i);
      end
    end
    for (int k = 0; k < 3; k++) begin
      ext       = {mag1[k], {(WM_W-1){1'b0}}} >> pos;
      wmag_c[k] = ext[WM_W-1:0];
    end
  end

  always_comb begin
    sq_init      = '0;
    sq_init.n    = sum4;
    sq_init.wmag = wmag4;
    sq_init.sgn  = sgn4;
    sq_init.zero = zero4;
    sq_init.side = side4;
  end

  always_comb begin
    dv_init      = '0;
    dv_init.rt   = sq[SQRT_N-1].root;
    dv_init.sgn  = sq[SQRT_N-1].sgn;
    dv_init.zero = sq[SQRT_N-1].zero;
    dv_init.side = sq[SQRT_N-1].side;
    for (int k = 0; k < 3; k++) begin
      dv_init.rem[k]  = DREM_W'(sq[SQRT_N-1].wmag[k] >> 1);
      dv_init.wlsb[k] = sq[SQRT_N-1].wmag[k][0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      for (int i = 0; i < SQRT_N; i++) vsq[i] <= 1'b0;
      for (int i = 0; i < DIV_N; i++) vdv[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      vsq[0] <= v4;
      for (int i = 1; i < SQRT_N; i++) vsq[i] <= vsq[i-1];
      vdv[0] <= vsq[SQRT_N-1];
      for (int i = 1; i < DIV_N; i++) vdv[i] <= vdv[i-1];
      out_valid <= vdv[DIV_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1  <= mag_in;
      for (int k = 0; k < 3; k++) sgn1[k] <= in_vec[k][VEC_W-1];
      side1 <= in_side;

      wmag2 <= wmag_c;
      sgn2  <= sgn1;
      zero2 <= (ormag == '0);
      side2 <= side1;

      for (int k = 0; k < 3; k++) sq3[k] <= wmag2[k] * wmag2[k];
      wmag3 <= wmag2;
      sgn3  <= sgn2;
      zero3 <= zero2;
      side3 <= side2;

      sum4  <= SUM_W'(sq3[0]) + SUM_W'(sq3[1]) + SUM_W'(sq3[2]);
      wmag4 <= wmag3;
      sgn4  <= sgn3;
      zero4 <= zero3;
      side4 <= side3;

      sq[0] <= sq_step(sq_init);
      for (int i = 1; i < SQRT_N; i++) sq[i] <= sq_step(sq[i-1]);

      dv[0] <= dv_step(dv_init, 1'b1);
      for (int i = 1; i < DIV_N; i++) dv[i] <= dv_step(dv[i-1], 1'b0);

      for (int k = 0; k < 3; k++) begin
        if (dv[DIV_N-1].zero) begin
          out_vec[k] <= '0;
        end else if (dv[DIV_N-1].sgn[k]) begin
          out_vec[k] <= -COMP_W'(dv[DIV_N-1].q[k]);
        end else begin
          out_vec[k] <= COMP_W'(dv[DIV_N-1].q[k]);
        end
      end
      out_zero <= dv[DIV_N-1].zero;
      out_side <= dv[DIV_N-1].side;
    end
  end

endmodule

// File: hw/rtl/lav_cross.sv
// Two-stage cross product r x f feeding the up-vector normaliser.
// Depends on lav_pkg.
module lav_cross import lav_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  side_t in_side,
  output logic  out_valid,
  output wvec_t out_vec,
  output side_t out_side
);

  localparam int PW = 2 * COMP_W;

  logic               v1;
  logic [3:0][PW-1:0] p1;
  side_t              side1;
  logic signed [PW:0] t0;
  logic signed [PW:0] t1;
  logic signed [PW:0] t2;

  always_comb begin
    t0 = (PW+1)'($signed(p1[0]));
    t1 = -(PW+1)'($signed(p1[1]));
    t2 = (PW+1)'($signed(p1[2])) - (PW+1)'($signed(p1[3]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1[0] <= $signed(in_side.r[1]) * $signed(in_side.f[2]);
      p1[1] <= $signed(in_side.r[0]) * $signed(in_side.f[2]);
      p1[2] <= $signed(in_side.r[0]) * $signed(in_side.f[1]);
      p1[3] <= $signed(in_side.r[1]) * $signed(in_side.f[0]);
      side1 <= in_side;
      out_vec[0] <= VEC_W'(t0);
      out_vec[1] <= VEC_W'(t1);
      out_vec[2] <= VEC_W'(t2);
      out_side   <= side1;
    end
  end

endmodule

// File: hw/rtl/lav_mat.sv
// Dot products with the eye point and assembly of the saturated matrix,
// three stages. Depends on lav_pkg.
module lav_mat import lav_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  side_t in_side,
  input  cvec_t in_u,
  output logic  out_valid,
  output mat_t  out_mat,
  output logic  out_degen
);

  localparam int PROD_W = COMP_W + IN_W;
  localparam int DOT_W  = PROD_W + 2;

  function automatic logic [IN_W-1:0] sat(logic signed [DOT_W:0] x);
    logic hi_same;
    hi_same = (x[DOT_W:IN_W-1] == '0) || (x[DOT_W:IN_W-1] == '1);
    if (hi_same) begin
      return x[IN_W-1:0];
    end else if (x[DOT_W]) begin
      return {1'b1, {(IN_W-1){1'b0}}};
    end
    return {1'b0, {(IN_W-1){1'b1}}};
  endfunction

  // Order of the three basis vectors: r, u, f
  logic                        va;
  logic [2:0][2:0][PROD_W-1:0] pa;
  cvec_t                       ra, ua, fa;
  logic                        da;
  logic                        vb;
  logic [2:0][DOT_W-1:0]       db;
  cvec_t                       rb, ub, fb;
  logic                        dgb;
  logic [2:0][DOT_W-1:0]       dsh;
  mat_t                        mc;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dsh[a] = $signed(db[a]) >>> FRAC_BITS;
    end
    mc = '0;
    if (!dgb) begin
      for (int j = 0; j < 3; j++) begin
        mc[j][0] = IN_W'($signed(rb[j]));
        mc[j][1] = IN_W'($signed(ub[j]));
        mc[j][2] = IN_W'(-$signed(fb[j]));
      end
      mc[3][0] = sat(-(DOT_W+1)'($signed(dsh[0])));
      mc[3][1] = sat(-(DOT_W+1)'($signed(dsh[1])));
      mc[3][2] = sat((DOT_W+1)'($signed(dsh[2])));
      mc[3][3] = IN_W'(1) << FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pa[0][k] <= $signed(in_side.r[k]) * $signed(in_side.eye[k]);
        pa[1][k] <= $signed(in_u[k]) * $signed(in_side.eye[k]);
        pa[2][k] <= $signed(in_side.f[k]) * $signed(in_side.eye[k]);
      end
      ra <= in_side.r;
      ua <= in_u;
      fa <= in_side.f;
      da <= in_side.degen;

      for (int a = 0; a < 3; a++) begin
        db[a] <= DOT_W'($signed(pa[a][0])) + DOT_W'($signed(pa[a][1]))
               + DOT_W'($signed(pa[a][2]));
      end
      rb  <= ra;
      ub  <= ua;
      fb  <= fa;
      dgb <= da;

      out_mat   <= mc;
      out_degen <= dgb;
    end
  end

endmodule

// File: hw/rtl/look_at_view_matrix_top.sv
// Top level of the look-at view matrix block: input stage, three
// normalisers, cross product, matrix assembly and column output register.
// Depends on lav_pkg, lav_unit3, lav_cross, lav_mat.
//
//  channel   handshake             payload
//  request   req_valid/req_stall   eye_x..eye_z, target_x..target_z
//  result    rsp_valid/rsp_stall   column_index, elem_row0..3, degenerate, is_last
//
// A request yields four results, one column per cycle while rsp_stall is low;
// the column register loads the next finished matrix as the last column of
// the one it holds is taken. Reset clears all valid bits. A result stall
// freezes the whole pipeline once a finished matrix waits behind the column
// register.
module look_at_view_matrix_top import lav_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [1:0]         column_index,
  output logic signed [31:0] elem_row0,
  output logic signed [31:0] elem_row1,
  output logic signed [31:0] elem_row2,
  output logic signed [31:0] elem_row3,
  output logic               degenerate,
  output logic               is_last
);

  logic              adv;
  logic              load_ok;
  logic              v0;
  wvec_t             d0;
  side_t             side0;
  logic signed [DIFF_W-1:0] dx, dy, dz;

  logic  uf_valid, uf_zero, ur_valid, ur_zero, cr_valid, uu_valid, uu_zero, mt_valid;
  cvec_t uf_vec, ur_vec, uu_vec;
  side_t uf_side, ur_side, cr_side, uu_side;
  side_t side_r, side_c, side_m;
  wvec_t rin_vec, cr_vec;
  mat_t  mt_mat;
  logic  mt_degen;

  mat_t              mat_q;
  logic              degen_q;
  logic              busy;
  logic [COL_W-1:0]  col;

  assign load_ok   = !busy || (col == COL_LAST && !rsp_stall);
  assign adv       = !mt_valid || load_ok;
  assign req_stall = !adv;

  always_comb begin
    dx = $signed({target_x[31], target_x}) - $signed({eye_x[31], eye_x});
    dy = $signed({target_y[31], target_y}) - $signed({eye_y[31], eye_y});
    dz = $signed({target_z[31], target_z}) - $signed({eye_z[31], eye_z});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0[0]       <= VEC_W'(dx);
      d0[1]       <= VEC_W'(dy);
      d0[2]       <= VEC_W'(dz);
      side0       <= '{eye: {eye_z, eye_y, eye_x}, f: '0, r: '0, degen: 1'b0};
    end
  end

  lav_unit3 u_unit_f (
    .clk, .rst, .adv,
    .in_valid (v0),       .in_vec (d0),      .in_side (side0),
    .out_valid(uf_valid), .out_vec(uf_vec),  .out_zero(uf_zero), .out_side(uf_side)
  );

  // Right vector input is (f_y, -f_x, 0).
  always_comb begin
    side_r       = uf_side;
    side_r.f     = uf_vec;
    side_r.degen = uf_side.degen | uf_zero;
    rin_vec[0]   = VEC_W'($signed(uf_vec[1]));
    rin_vec[1]   = VEC_W'(-(COMP_W+1)'($signed(uf_vec[0])));
    rin_vec[2]   = '0;
  end

  lav_unit3 u_unit_r (
    .clk, .rst, .adv,
    .in_valid (uf_valid), .in_vec (rin_vec), .in_side (side_r),
    .out_valid(ur_valid), .out_vec(ur_vec),  .out_zero(ur_zero), .out_side(ur_side)
  );

  always_comb begin
    side_c       = ur_side;
    side_c.r     = ur_vec;
    side_c.degen = ur_side.degen | ur_zero;
  end

  lav_cross u_cross (
    .clk, .rst, .adv,
    .in_valid (ur_valid), .in_side (side_c),
    .out_valid(cr_valid), .out_vec (cr_vec), .out_side(cr_side)
  );

  lav_unit3 u_unit_u (
    .clk, .rst, .adv,
    .in_valid (cr_valid), .in_vec (cr_vec),  .in_side (cr_side),
    .out_valid(uu_valid), .out_vec(uu_vec),  .out_zero(uu_zero), .out_side(uu_side)
  );

  always_comb begin
    side_m       = uu_side;
    side_m.degen = uu_side.degen | uu_zero;
  end

  lav_mat u_mat (
    .clk, .rst, .adv,
    .in_valid (uu_valid), .in_side(side_m), .in_u(uu_vec),
    .out_valid(mt_valid), .out_mat(mt_mat), .out_degen(mt_degen)
  );

  // Column register: holds one finished matrix and walks its four columns.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      col  <= '0;
    end else if (mt_valid && load_ok) begin
      busy <= 1'b1;
      col  <= '0;
    end else if (busy && !rsp_stall) begin
      if (col == COL_LAST) begin
        busy <= 1'b0;
      end
      col <= col + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mt_valid && load_ok) begin
      mat_q   <= mt_mat;
      degen_q <= mt_degen;
    end
  end

  assign rsp_valid    = busy;
  assign column_index = col;
  assign elem_row0    = mat_q[col][0];
  assign elem_row1    = mat_q[col][1];
  assign elem_row2    = mat_q[col][2];
  assign elem_row3    = mat_q[col][3];
  assign degenerate   = degen_q;
  assign is_last      = (col == COL_LAST);

`include "look_at_view_matrix_top_assert.svh"

  `LAV_ASSERT_NEXT(a_col_step, rsp_valid && !rsp_stall && !is_last,
    rsp_valid && column_index == $past(column_index) + 2'd1, "column sequence broken")
  `LAV_ASSERT_NEXT(a_degen_hold, rsp_valid && !is_last,
    degenerate == $past(degenerate), "degenerate flag changed inside a matrix")
  `LAV_ASSERT_NOW(a_degen_zero, rsp_valid && degenerate,
    elem_row0 == 0 && elem_row1 == 0 && elem_row2 == 0 && elem_row3 == 0,
    "degenerate matrix has nonzero entries")
  `LAV_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid, "request stalled with no result waiting")

endmodule

// File: test/tb_look_at_view_matrix_top.sv
// Self-checking testbench for look_at_view_matrix_top: random and directed
// eye/target requests, column-by-column comparison with a behavioural model.
// Depends on lav_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_look_at_view_matrix_top;
  import lav_pkg::*;

  typedef longint vec3_t[3];

  typedef struct {
    logic signed [31:0] ex, ey, ez, tx, ty, tz;
  } view_req_t;

  typedef struct {
    logic [1:0]         col;
    logic signed [31:0] row[4];
    logic               degen;
    logic               last;
  } column_t;

  localparam longint ONE_Q = longint'(1) << FRAC_BITS;
  localparam longint LO_BOUND = longint'(1) << 29;
  localparam longint HI_BOUND = longint'(1) << 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic signed [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
  logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [1:0] column_index;
  logic signed [31:0] elem_row0, elem_row1, elem_row2, elem_row3;
  logic degenerate, is_last;

  view_req_t pending_reqs[$];
  column_t   expected_cols[$];
  int        mismatches = 0;
  bit        hold_off = 1'b0;
  longint    cycle_no = 0;

  look_at_view_matrix_top u_top (.*);

  always #5 clk = ~clk;

  function automatic longint isqrt(longint unsigned n);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic bit unit_vec(input vec3_t v, output vec3_t o);
    longint m = 0, rt;
    vec3_t w;
    longint unsigned acc = 0;
    int s = 0;
    for (int i = 0; i < 3; i++) begin
      if ((v[i] < 0 ? -v[i] : v[i]) > m) m = v[i] < 0 ? -v[i] : v[i];
      o[i] = 0;
    end
    if (m == 0) return 1'b0;
    if (m >= HI_BOUND) begin
      while ((m >>> s) >= HI_BOUND) s++;
      for (int i = 0; i < 3; i++) w[i] = v[i] / (longint'(1) << s);
    end else begin
      while ((m <<< s) < LO_BOUND) s++;
      for (int i = 0; i < 3; i++) w[i] = v[i] * (longint'(1) << s);
    end
    for (int i = 0; i < 3; i++) acc += longint'(w[i] * w[i]);
    rt = isqrt(acc);
    for (int i = 0; i < 3; i++) o[i] = (w[i] * ONE_Q) / rt;
    return 1'b1;
  endfunction

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // The shift floors, which is what the dot products with the eye need.
  function automatic longint dot_with_eye(vec3_t a, vec3_t e);
    return (a[0] * e[0] + a[1] * e[1] + a[2] * e[2]) >>> FRAC_BITS;
  endfunction

  function automatic void predict_view_matrix(view_req_t q);
    vec3_t eye, d, f, r, u, tmp;
    longint mtx[4][4];
    bit ok;
    column_t c;
    eye[0] = q.ex; eye[1] = q.ey; eye[2] = q.ez;
    d[0] = longint'(q.tx) - eye[0];
    d[1] = longint'(q.ty) - eye[1];
    d[2] = longint'(q.tz) - eye[2];
    ok = unit_vec(d, f);
    if (ok) begin
      tmp[0] = f[1]; tmp[1] = -f[0]; tmp[2] = 0;
      ok = unit_vec(tmp, r);
    end
    if (ok) begin
      tmp[0] = r[1] * f[2];
      tmp[1] = -(r[0] * f[2]);
      tmp[2] = r[0] * f[1] - r[1] * f[0];
      ok = unit_vec(tmp, u);
    end
    for (int j = 0; j < 4; j++)
      for (int k = 0; k < 4; k++) mtx[j][k] = 0;
    if (ok) begin
      for (int j = 0; j < 3; j++) begin
        mtx[j][0] = r[j];
        mtx[j][1] = u[j];
        mtx[j][2] = -f[j];
      end
      mtx[3][0] = -dot_with_eye(r, eye);
      mtx[3][1] = -dot_with_eye(u, eye);
      mtx[3][2] = dot_with_eye(f, eye);
      mtx[3][3] = ONE_Q;
    end
    for (int j = 0; j < 4; j++) begin
      c.col = j[1:0];
      for (int k = 0; k < 4; k++) c.row[k] = clamp32(mtx[j][k]);
      c.degen = !ok;
      c.last = (c.col == COL_LAST);
      expected_cols.push_back(c);
    end
  endfunction

  // Request driver: one nonblocking write of req_valid per edge.
  int send_wait = 0;
  always @(posedge clk) begin
    view_req_t nxt;
    bit offer;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      offer = 1'b0;
      if (req_valid && !req_stall) begin
        predict_view_matrix('{eye_x, eye_y, eye_z, target_x, target_y, target_z});
        send_wait = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) send_wait = 0;
        offer = (send_wait == 0 && pending_reqs.size() > 0);
      end else if (!req_valid) begin
        if (send_wait > 0) send_wait--;
        else offer = pending_reqs.size() > 0;
      end else begin
        offer = 1'b1;
      end
      if (offer && !(req_valid && req_stall)) begin
        nxt = pending_reqs.pop_front();
        eye_x <= nxt.ex; eye_y <= nxt.ey; eye_z <= nxt.ez;
        target_x <= nxt.tx; target_y <= nxt.ty; target_z <= nxt.tz;
      end
      req_valid <= offer;
    end
  end

  // Long hold-off on the result side so that the pipeline backs up.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    hold_off <= (cycle_no >= 3000 && cycle_no < 3800);
  end

  int stall_left = 0;
  always @(posedge clk) begin
    column_t e;
    if (rsp_valid && !rsp_stall) begin
      if (expected_cols.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected column %0d", column_index);
      end else begin
        e = expected_cols.pop_front();
        if (column_index !== e.col || elem_row0 !== e.row[0] || elem_row1 !== e.row[1] ||
            elem_row2 !== e.row[2] || elem_row3 !== e.row[3] ||
            degenerate !== e.degen || is_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp col %0d %0d %0d %0d %0d dg %0d last %0d / got %0d %0d %0d %0d %0d dg %0d last %0d",
                     e.col, e.row[0], e.row[1], e.row[2], e.row[3], e.degen, e.last,
                     column_index, elem_row0, elem_row1, elem_row2, elem_row3,
                     degenerate, is_last);
        end
      end
      stall_left = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    rsp_stall <= hold_off || (stall_left > 0);
  end

  function automatic logic signed [31:0] pick_coord(int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h003fffff)) - 32'sh00200000;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sh0;
          default: return 32'sh00010000;
        endcase
      end
    endcase
  endfunction

  initial begin
    view_req_t q;
    int kind;
    // Directed: extremes, eye equal to target, forward along z, saturation.
    pending_reqs.push_back('{0, 0, 0, 0, 0, 0});
    pending_reqs.push_back('{32'sh7fffffff, 32'sh80000000, 5, 32'sh7fffffff,
                             32'sh80000000, 5});
    pending_reqs.push_back('{0, 0, 0, 0, 0, 32'sh00010000});
    pending_reqs.push_back('{3, 4, 32'sh80000000, 3, 4, 32'sh7fffffff});
    pending_reqs.push_back('{0, 0, 32'sh80000000, 1, 0, 32'sh7fffffff});
    pending_reqs.push_back('{0, 0, 32'sh7fffffff, 0, -1, 32'sh80000000});
    pending_reqs.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000,
                             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
    pending_reqs.push_back('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                             32'sh80000000, 32'sh80000000, 32'sh80000000});
    pending_reqs.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0, 0});
    pending_reqs.push_back('{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1, 2, 3});
    pending_reqs.push_back('{0, 0, 0, 32'sh00010000, 0, 0});
    pending_reqs.push_back('{0, 0, 0, 0, 32'sh00010000, 0});
    pending_reqs.push_back('{0, 0, 0, -1, -1, -1});
    pending_reqs.push_back('{32'sh00050000, 32'sh00050000, 32'sh00050000, 0, 0, 0});
    pending_reqs.push_back('{-1, -1, -1, -1, -1, -1});
    for (int n = 0; n < 420; n++) begin
      kind = $urandom_range(0, 19);
      if (kind < 10) kind = 0; else if (kind < 15) kind = 1; else if (kind < 17) kind = 2;
      q.ex = pick_coord(kind < 3 ? kind : 0);
      q.ey = pick_coord(kind < 3 ? kind : 0);
      q.ez = pick_coord(kind < 3 ? kind : 0);
      q.tx = pick_coord(kind < 3 ? kind : 0);
      q.ty = pick_coord(kind < 3 ? kind : 0);
      q.tz = pick_coord(kind < 3 ? kind : 0);
      if (kind == 17) begin
        q.tx = q.ex; q.ty = q.ey; q.tz = q.ez;
      end else if (kind == 18) begin
        q.tx = q.ex; q.ty = q.ey;
      end else if (kind == 19) begin
        q.tx = q.ex + $signed($urandom_range(0, 14)) - 7;
        q.ty = q.ey + $signed($urandom_range(0, 14)) - 7;
      end
      pending_reqs.push_back(q);
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0 && !req_valid);
    wait (expected_cols.size() == 0);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_cols.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
